// ===== hdl/adbd_pkg.sv =====
package adbd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HDR_BYTES   = 24;
    localparam int unsigned HDR_WORDS   = HDR_BYTES / 4;
    localparam int unsigned HDR_POS_W   = $clog2(HDR_BYTES);
    localparam int unsigned HDR_IDX_W   = $clog2(HDR_WORDS);
    localparam logic [WORD_W-1:0] MAGIC_XOR = 32'hffff_ffff;

    // header word slots, in stream order
    localparam int unsigned W_COMMAND  = 0;
    localparam int unsigned W_ARG0     = 1;
    localparam int unsigned W_ARG1     = 2;
    localparam int unsigned W_LENGTH   = 3;
    localparam int unsigned W_CHECKSUM = 4;
    localparam int unsigned W_MAGIC    = 5;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MAGIC = 2'd1,
        STATUS_BAD_SUM   = 2'd2,
        STATUS_FAULT     = 2'd3
    } status_t;

    typedef struct packed {
        logic              is_header;
        logic [WORD_W-1:0] command;
        logic [WORD_W-1:0] arg_zero;
        logic [WORD_W-1:0] arg_one;
        logic [WORD_W-1:0] msg_length;
        logic [7:0]        body_byte;
        logic              last;
        status_t           status;
    } result_t;

endpackage

// ===== hdl/adbd_rx_if.sv =====
interface adbd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       transfer_fault;

    modport source (output valid, output data_byte, output transfer_fault, input ready);
    modport sink (input valid, input data_byte, input transfer_fault, output ready);
endinterface

// ===== hdl/adbd_msg_if.sv =====
interface adbd_msg_if;
    logic                          valid;
    logic                          ready;
    logic                          is_header;
    logic [adbd_pkg::WORD_W-1:0]   command;
    logic [adbd_pkg::WORD_W-1:0]   arg_zero;
    logic [adbd_pkg::WORD_W-1:0]   arg_one;
    logic [adbd_pkg::WORD_W-1:0]   msg_length;
    logic [7:0]                    body_byte;
    logic                          last;
    adbd_pkg::status_t             status;

    modport source (
        output valid, output is_header, output command, output arg_zero,
        output arg_one, output msg_length, output body_byte, output last,
        output status, input ready
    );
    modport sink (
        input valid, input is_header, input command, input arg_zero,
        input arg_one, input msg_length, input body_byte, input last,
        input status, output ready
    );
endinterface

// ===== hdl/adbd_out_skid.sv =====
module adbd_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  adbd_pkg::result_t push_data,
    output logic              can_push,
    adbd_msg_if.source        msg
);

    logic              out_valid_reg;
    adbd_pkg::result_t out_data_reg;
    logic              skid_valid_reg;
    adbd_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop      = out_valid_reg && msg.ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign msg.valid       = out_valid_reg;
    assign msg.is_header   = out_data_reg.is_header;
    assign msg.command     = out_data_reg.command;
    assign msg.arg_zero    = out_data_reg.arg_zero;
    assign msg.arg_one     = out_data_reg.arg_one;
    assign msg.msg_length  = out_data_reg.msg_length;
    assign msg.body_byte   = out_data_reg.body_byte;
    assign msg.last        = out_data_reg.last;
    assign msg.status      = out_data_reg.status;

endmodule

// ===== hdl/adb_message_deframer_core.sv =====
// each result is registered into the output register, or the skid register while msg stalls
// throughput: one byte per cycle while rx.ready is high; the header byte count, body count
// and checksum add all advance in the same cycle as the transfer
// rx.ready drops only while both the output register and the skid register hold results
// reset (rst_n, async, active low) returns to header phase and empties the output stage;
// stored header words are not cleared and are only read after a full header
module adb_message_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    adbd_rx_if.sink    rx,
    adbd_msg_if.source msg
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_HALT   = 2'd2
    } phase_t;

    localparam int unsigned W = adbd_pkg::WORD_W;

    phase_t                            phase_reg, phase_next;
    logic [adbd_pkg::HDR_POS_W-1:0]    hdr_pos_reg, hdr_pos_next;
    logic [W-1:0]                      hdr_words_reg [adbd_pkg::HDR_WORDS];
    logic [W-1:0]                      remaining_reg, remaining_next;
    logic [W-1:0]                      sum_reg, sum_next;

    logic                              accept;
    logic                              can_push;
    logic                              push;
    adbd_pkg::result_t                 res;
    logic                              hdr_write;
    logic [adbd_pkg::HDR_IDX_W-1:0]    hdr_idx;
    logic [1:0]                        hdr_lane;
    logic [W-1:0]                      magic_word;
    logic                              hdr_done;

    assign rx.ready = can_push;
    assign accept   = rx.valid && rx.ready;
    assign hdr_idx  = hdr_pos_reg[adbd_pkg::HDR_POS_W-1:2];
    assign hdr_lane = hdr_pos_reg[1:0];
    assign hdr_done = (hdr_pos_reg == adbd_pkg::HDR_POS_W'(adbd_pkg::HDR_BYTES - 1));
    // magic word with its top byte taken straight from the current transfer
    assign magic_word = {rx.data_byte, hdr_words_reg[adbd_pkg::W_MAGIC][W-9:0]};

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        push           = 1'b0;
        hdr_write      = 1'b0;
        res            = '0;
        res.command     = hdr_words_reg[adbd_pkg::W_COMMAND];
        res.arg_zero    = hdr_words_reg[adbd_pkg::W_ARG0];
        res.arg_one     = hdr_words_reg[adbd_pkg::W_ARG1];
        res.msg_length  = hdr_words_reg[adbd_pkg::W_LENGTH];
        res.status      = adbd_pkg::STATUS_OK;

        if (accept && (phase_reg == PH_HEADER || phase_reg == PH_BODY))
        begin
            if (rx.transfer_fault)
            begin
                push       = 1'b1;
                res        = '0;
                res.last   = 1'b1;
                res.status = adbd_pkg::STATUS_FAULT;
                phase_next = PH_HALT;
            end
            else if (phase_reg == PH_HEADER)
            begin
                hdr_write = 1'b1;
                if (!hdr_done)
                begin
                    hdr_pos_next = hdr_pos_reg + adbd_pkg::HDR_POS_W'(1);
                end
                else
                begin
                    hdr_pos_next = '0;
                    push         = 1'b1;
                    if ((hdr_words_reg[adbd_pkg::W_COMMAND] ^ adbd_pkg::MAGIC_XOR)
                        != magic_word)
                    begin
                        res        = '0;
                        res.last   = 1'b1;
                        res.status = adbd_pkg::STATUS_BAD_MAGIC;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        res.is_header = 1'b1;
                        if (hdr_words_reg[adbd_pkg::W_LENGTH] == '0)
                        begin
                            res.last = 1'b1;
                        end
                        else
                        begin
                            remaining_next = hdr_words_reg[adbd_pkg::W_LENGTH];
                            sum_next       = '0;
                            phase_next     = PH_BODY;
                        end
                    end
                end
            end
            else
            begin
                push          = 1'b1;
                sum_next      = sum_reg + W'(rx.data_byte);
                res.body_byte = rx.data_byte;
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - W'(1);
                end
                if (remaining_reg <= W'(1))
                begin
                    res.last = 1'b1;
                    if (sum_next != hdr_words_reg[adbd_pkg::W_CHECKSUM])
                    begin
                        res.body_byte = '0;
                        res.status    = adbd_pkg::STATUS_BAD_SUM;
                        phase_next    = PH_HALT;
                    end
                    else
                    begin
                        sum_next   = '0;
                        phase_next = PH_HEADER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_pos_reg   <= '0;
            remaining_reg <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
        end
    end

    // little-endian byte lanes of the header words
    always_ff @(posedge clk)
    begin
        if (hdr_write)
        begin
            case (hdr_lane)
                2'd0:    hdr_words_reg[hdr_idx][7:0]   <= rx.data_byte;
                2'd1:    hdr_words_reg[hdr_idx][15:8]  <= rx.data_byte;
                2'd2:    hdr_words_reg[hdr_idx][23:16] <= rx.data_byte;
                default: hdr_words_reg[hdr_idx][31:24] <= rx.data_byte;
            endcase
        end
    end

    adbd_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .can_push  (can_push),
        .msg       (msg)
    );

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("left halted state without reset");

    a_hdr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg < adbd_pkg::HDR_POS_W'(adbd_pkg::HDR_BYTES))
        else $error("header byte position out of range");

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> remaining_reg != '0)
        else $error("body phase with no bytes remaining");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.status != adbd_pkg::STATUS_OK |-> msg.last && !msg.is_header)
        else $error("error result not marked last");

endmodule
